// ===== rtl/bls_pkg.sv =====
// Shared constants and types for the line stepper.
// No dependencies; compile before every other file of the block.
package bls_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic en;
        logic op;
    } t_bls_ctl;

endpackage

// ===== rtl/bls_ifs.sv =====
// Channel interfaces: line request in, fragment out.
// Depends on bls_pkg for the default coordinate width.
interface bls_req_if #(parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bls_frag_if #(parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] frag_x;
    logic signed [COORD_BITS-1:0] frag_y;
    logic                         frag_valid;

    modport source (output valid, frag_x, frag_y, frag_valid, input ready);
    modport sink   (input valid, frag_x, frag_y, frag_valid, output ready);
endinterface

// ===== rtl/bls_engine.sv =====
// Line state and combinational load/step logic of the stepper.
// Depends on bls_pkg; driven by bresenham_line_stepper.
module bls_engine #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bls_pkg::t_bls_ctl            i_ctl,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic signed [COORD_BITS-1:0] o_frag_x,
    output logic signed [COORD_BITS-1:0] o_frag_y,
    output logic                         o_frag_valid
);
    import bls_pkg::*;

    localparam int D_W = COORD_BITS + 1;
    localparam int T_W = COORD_BITS + 2;
    localparam int E_W = COORD_BITS + 3;

    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y, n_stop_x, n_stop_y;
    logic [E_W-1:0]        r_err, n_err;
    logic [T_W-1:0]        r_tdx, r_tdy, n_tdx, n_tdy;
    logic                  r_xneg, r_yneg, r_xmaj, r_mpos, r_active;
    logic                  n_xneg, n_yneg, n_xmaj, n_mpos, n_active;

    logic [D_W-1:0]        w_dx, w_dy, w_adx, w_ady;
    logic [T_W-1:0]        w_tdx, w_tdy;
    logic                  w_xneg, w_yneg, w_xmaj, w_minor, w_at_end;
    logic [E_W-1:0]        w_sub, w_add;
    logic [COORD_BITS-1:0] w_xinc, w_yinc;

    always_comb begin
        w_dx   = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
        w_dy   = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};
        w_xneg = w_dx[D_W-1];
        w_yneg = w_dy[D_W-1];
        w_adx  = w_xneg ? (~w_dx + 1'b1) : w_dx;
        w_ady  = w_yneg ? (~w_dy + 1'b1) : w_dy;
        w_tdx  = {w_adx, 1'b0};
        w_tdy  = {w_ady, 1'b0};
        w_xmaj = w_tdx > w_tdy;

        w_minor  = ($signed(r_err) > 0) || ((r_err == '0) && r_mpos);
        w_at_end = r_xmaj ? (r_cur_x == r_stop_x) : (r_cur_y == r_stop_y);
        w_sub    = r_xmaj ? {1'b0, r_tdx} : {1'b0, r_tdy};
        w_add    = r_xmaj ? {1'b0, r_tdy} : {1'b0, r_tdx};
        w_xinc   = r_xneg ? '1 : COORD_BITS'(1);
        w_yinc   = r_yneg ? '1 : COORD_BITS'(1);

        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_stop_x = r_stop_x;
        n_stop_y = r_stop_y;
        n_err    = r_err;
        n_tdx    = r_tdx;
        n_tdy    = r_tdy;
        n_xneg   = r_xneg;
        n_yneg   = r_yneg;
        n_xmaj   = r_xmaj;
        n_mpos   = r_mpos;
        n_active = r_active;

        if (i_ctl.op == OP_LOAD) begin
            n_cur_x  = i_start_x;
            n_cur_y  = i_start_y;
            n_stop_x = i_end_x;
            n_stop_y = i_end_y;
            n_xneg   = w_xneg;
            n_yneg   = w_yneg;
            n_tdx    = w_tdx;
            n_tdy    = w_tdy;
            n_xmaj   = w_xmaj;
            if (w_xmaj) begin
                n_mpos   = !w_xneg;
                n_err    = {1'b0, w_tdy} - {2'b00, w_adx};
                n_active = i_start_x != i_end_x;
            end else begin
                n_mpos   = !w_yneg;
                n_err    = {1'b0, w_tdx} - {2'b00, w_ady};
                n_active = i_start_y != i_end_y;
            end
        end else if (r_active) begin
            if (w_at_end) begin
                n_active = 1'b0;
            end else begin
                n_err = r_err + w_add - (w_minor ? w_sub : '0);
                if (r_xmaj) begin
                    n_cur_x = r_cur_x + w_xinc;
                    if (w_minor) begin
                        n_cur_y = r_cur_y + w_yinc;
                    end
                end else begin
                    n_cur_y = r_cur_y + w_yinc;
                    if (w_minor) begin
                        n_cur_x = r_cur_x + w_xinc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_stop_x <= '0;
            r_stop_y <= '0;
            r_err    <= '0;
            r_tdx    <= '0;
            r_tdy    <= '0;
            r_xneg   <= 1'b0;
            r_yneg   <= 1'b0;
            r_xmaj   <= 1'b0;
            r_mpos   <= 1'b0;
            r_active <= 1'b0;
        end else if (i_ctl.en) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_stop_x <= n_stop_x;
            r_stop_y <= n_stop_y;
            r_err    <= n_err;
            r_tdx    <= n_tdx;
            r_tdy    <= n_tdy;
            r_xneg   <= n_xneg;
            r_yneg   <= n_yneg;
            r_xmaj   <= n_xmaj;
            r_mpos   <= n_mpos;
            r_active <= n_active;
        end
    end

    assign o_frag_x     = n_active ? n_cur_x : '0;
    assign o_frag_y     = n_active ? n_cur_y : '0;
    assign o_frag_valid = n_active;

`ifndef SYNTH
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.en && i_ctl.op == OP_LOAD && i_start_x == i_end_x && i_start_y == i_end_y
        |=> !r_active)
        else $error("zero-length line left active");

    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.en && i_ctl.op == OP_STEP && !r_active
        |=> $stable(r_cur_x) && $stable(r_cur_y) && !r_active)
        else $error("step without line moved the fragment");

    a_endpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.en && i_ctl.op == OP_STEP && r_active && w_at_end |=> !r_active)
        else $error("step at endpoint did not finish the line");

    a_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xmaj |-> r_tdx > r_tdy)
        else $error("x chosen as major axis with smaller delta");
`endif

endmodule

// ===== rtl/bresenham_line_stepper.sv =====
// Top level of the midpoint line stepper: request register, engine, fragment register.
// Depends on bls_pkg, bls_ifs (bls_req_if, bls_frag_if) and bls_engine.
//
//  channel  | dir | payload                                    | handshake
//  i_req    | in  | opcode, start_x, start_y, end_x, end_y     | valid/ready
//  o_frag   | out | frag_x, frag_y, frag_valid                 | valid/ready
//
// One request per cycle sustained while o_frag is ready; after acceptance a request goes
// to the request register, then through the load/step logic into the fragment register.
// The single step of the error term and coordinates sets the cycle.
// Reset clears the line state and the valid flags: no line, no fragment pending.
// A stalled fragment holds both registers; a request is still taken while the request register is empty.
module bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bls_req_if.sink    i_req,
    bls_frag_if.source o_frag
);
    import bls_pkg::*;

    logic                         r_in_valid;
    logic                         r_op;
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_fx, r_fy;
    logic                         r_fv;

    logic                         w_adv;
    logic                         w_take;
    t_bls_ctl                     w_ctl;
    logic signed [COORD_BITS-1:0] w_fx, w_fy;
    logic                         w_fv;

    assign w_adv       = r_in_valid && (!r_out_valid || o_frag.ready);
    assign w_take      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_ctl.en    = w_adv;
    assign w_ctl.op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_frag.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= i_req.opcode;
            r_sx <= i_req.start_x;
            r_sy <= i_req.start_y;
            r_ex <= i_req.end_x;
            r_ey <= i_req.end_y;
        end
        if (w_adv) begin
            r_fx <= w_fx;
            r_fy <= w_fy;
            r_fv <= w_fv;
        end
    end

    bls_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_start_x    (r_sx),
        .i_start_y    (r_sy),
        .i_end_x      (r_ex),
        .i_end_y      (r_ey),
        .o_frag_x     (w_fx),
        .o_frag_y     (w_fy),
        .o_frag_valid (w_fv)
    );

    assign o_frag.valid      = r_out_valid;
    assign o_frag.frag_x     = r_fx;
    assign o_frag.frag_y     = r_fy;
    assign o_frag.frag_valid = r_fv;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for bresenham_line_stepper: directed rows, then random line sequences.
// Expected fragments come from an in-bench line predictor or a directed row's own value, checked in request order.
// Depends on bls_pkg, bls_ifs and the bresenham_line_stepper RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int DW           = CW + 2;
    localparam int EW           = CW + 3;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 1600;
    localparam int QUIET_FROM   = 1350;
    localparam int LIMIT_CYCLES = 500000;
    localparam int C_MIN        = -(1 << (CW - 1));
    localparam int C_MAX        = (1 << (CW - 1)) - 1;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic   op;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_req;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   v;
    } t_frag;

    typedef struct packed {
        t_req  r;
        logic  typed;
        t_frag f;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bls_req_if  #(.COORD_BITS(CW)) req_if ();
    bls_frag_if #(.COORD_BITS(CW)) frag_if ();

    bresenham_line_stepper #(.COORD_BITS(CW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_frag  (frag_if.source)
    );

    // line predictor state
    t_coord               ln_x, ln_y, ln_stop_x, ln_stop_y;
    logic signed [EW-1:0] ln_err;
    logic [DW-1:0]        ln_2dx, ln_2dy;
    logic                 ln_xneg, ln_yneg, ln_xmaj, ln_majpos, ln_on;

    t_frag    frag_expect_q[$];
    t_dir_row dir_rows [N_DIRECTED];

    int  cycle_count   = 0;
    int  mismatches    = 0;
    int  frags_checked = 0;
    int  req_count;
    int  load_count;
    int  live_count;
    int  lines_finished;
    int  sink_hold_cycles;
    bit  quiet;
    bit  gaps_on;

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    function automatic t_frag advance_line(input t_req r);
        int    dx, dy;
        logic  minor;
        t_frag f;
        if (r.op == OP_LOAD) begin
            dx        = int'(r.ex) - int'(r.sx);
            dy        = int'(r.ey) - int'(r.sy);
            ln_x      = r.sx;
            ln_y      = r.sy;
            ln_stop_x = r.ex;
            ln_stop_y = r.ey;
            ln_xneg   = dx < 0;
            ln_yneg   = dy < 0;
            ln_2dx    = DW'(2 * (dx < 0 ? -dx : dx));
            ln_2dy    = DW'(2 * (dy < 0 ? -dy : dy));
            if (ln_2dx > ln_2dy) begin
                ln_xmaj   = 1'b1;
                ln_majpos = !ln_xneg;
                ln_err    = EW'(int'(ln_2dy) - int'(ln_2dx) / 2);
                ln_on     = r.sx != r.ex;
            end else begin
                ln_xmaj   = 1'b0;
                ln_majpos = !ln_yneg;
                ln_err    = EW'(int'(ln_2dx) - int'(ln_2dy) / 2);
                ln_on     = r.sy != r.ey;
            end
        end else if (ln_on) begin
            minor = (ln_err > 0) || (ln_err == 0 && ln_majpos);
            if (ln_xmaj) begin
                if (ln_x == ln_stop_x) begin
                    ln_on = 1'b0;
                    lines_finished++;
                end else begin
                    if (minor) begin
                        ln_y   = ln_y + (ln_yneg ? t_coord'(-1) : t_coord'(1));
                        ln_err = ln_err - $signed({1'b0, ln_2dx});
                    end
                    ln_x   = ln_x + (ln_xneg ? t_coord'(-1) : t_coord'(1));
                    ln_err = ln_err + $signed({1'b0, ln_2dy});
                end
            end else begin
                if (ln_y == ln_stop_y) begin
                    ln_on = 1'b0;
                    lines_finished++;
                end else begin
                    if (minor) begin
                        ln_x   = ln_x + (ln_xneg ? t_coord'(-1) : t_coord'(1));
                        ln_err = ln_err - $signed({1'b0, ln_2dy});
                    end
                    ln_y   = ln_y + (ln_yneg ? t_coord'(-1) : t_coord'(1));
                    ln_err = ln_err + $signed({1'b0, ln_2dx});
                end
            end
        end
        f.v = ln_on;
        f.x = ln_on ? ln_x : '0;
        f.y = ln_on ? ln_y : '0;
        return f;
    endfunction

    function automatic t_req step_req();
        t_req r;
        r.op = OP_STEP;
        r.sx = t_coord'($urandom);
        r.sy = t_coord'($urandom);
        r.ex = t_coord'($urandom);
        r.ey = t_coord'($urandom);
        return r;
    endfunction

    function automatic int clamp_end(input int s, input int d);
        return (s + d > C_MAX || s + d < C_MIN) ? s - d : s + d;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_request(input t_req r, input bit typed, input t_frag typed_frag);
        t_frag f;
        req_if.valid   <= 1'b1;
        req_if.opcode  <= r.op;
        req_if.start_x <= r.sx;
        req_if.start_y <= r.sy;
        req_if.end_x   <= r.ex;
        req_if.end_y   <= r.ey;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        if (r.op == OP_LOAD || ln_on) live_count++;
        if (r.op == OP_LOAD) load_count++;
        req_count++;
        f = advance_line(r);
        frag_expect_q.push_back(typed ? typed_frag : f);
        @(negedge i_clk);
    endtask

    task automatic send_request(input t_req r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        offer_request(r, 1'b0, '0);
    endtask

    // fragment sink: random stalls, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        frag_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!hold_done && sink_hold_cycles > 0) begin
                hold_done     = 1'b1;
                frag_if.ready <= 1'b0;
                repeat (sink_hold_cycles) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                frag_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end else begin
                frag_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_frag want;
        if (i_rst_n === 1'b1 && frag_if.valid === 1'b1 && frag_if.ready === 1'b1) begin
            if (frag_expect_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected fragment x=%0d y=%0d v=%0b", $time,
                         frag_if.frag_x, frag_if.frag_y, frag_if.frag_valid);
            end else begin
                want = frag_expect_q.pop_front();
                frags_checked++;
                if (frag_if.frag_x !== want.x || frag_if.frag_y !== want.y ||
                    frag_if.frag_valid !== want.v) begin
                    mismatches++;
                    $display("%0t: fragment mismatch: expected x=%0d y=%0d v=%0b, got x=%0d y=%0d v=%0b",
                             $time, want.x, want.y, want.v,
                             frag_if.frag_x, frag_if.frag_y, frag_if.frag_valid);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d fragments outstanding", $time, frag_expect_q.size());
            $display("** bresenham_line_stepper: FAILED **");
            $finish;
        end
    end

    initial begin
        t_req r;
        int   sx, sy, ex, ey, dx, dy, len, nsteps, span, kind;
        bit   held, paused;

        req_count        = 0;
        load_count       = 0;
        live_count       = 0;
        lines_finished   = 0;
        sink_hold_cycles = 0;
        quiet            = 1'b0;
        gaps_on          = 1'b0;
        held             = 1'b0;
        paused           = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = OP_LOAD;
        req_if.start_x   = '0;
        req_if.start_y   = '0;
        req_if.end_x     = '0;
        req_if.end_y     = '0;
        {ln_x, ln_y, ln_stop_x, ln_stop_y} = '0;
        {ln_err, ln_2dx, ln_2dy}           = '0;
        {ln_xneg, ln_yneg, ln_xmaj, ln_majpos, ln_on} = '0;

        dir_rows = '{
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b1, '{    0,     0, 1'b0}},
            '{'{OP_LOAD,     0,     0,    0,    0}, 1'b1, '{    0,     0, 1'b0}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b1, '{    0,     0, 1'b0}},
            '{'{OP_LOAD, -2048, -2048, 2047, 2047}, 1'b1, '{-2048, -2048, 1'b1}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_LOAD,  2047, -2048, -2048, 2047}, 1'b1, '{ 2047, -2048, 1'b1}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_LOAD,     0,     0,    4,    2}, 1'b1, '{    0,     0, 1'b1}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_LOAD,     0,     0,   -4,   -2}, 1'b1, '{    0,     0, 1'b1}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_LOAD,     0,     0,    1,    0}, 1'b1, '{    0,     0, 1'b1}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b1, '{    0,     0, 1'b0}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b1, '{    0,     0, 1'b0}},
            '{'{OP_LOAD,     3,     9,    1,    2}, 1'b1, '{    3,     9, 1'b1}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_LOAD,  2047,  2047, 2047, 2047}, 1'b1, '{    0,     0, 1'b0}},
            '{'{OP_LOAD, -2048,     5, 2047,    6}, 1'b1, '{-2048,     5, 1'b1}},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0},
            '{'{OP_STEP,     0,     0,    0,    0}, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) offer_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].f);

        live_count = 0;
        while (live_count < N_RANDOM) begin
            if (!held && live_count >= 400) begin
                held             = 1'b1;
                sink_hold_cycles = 300;
            end
            if (!paused && live_count >= 800) begin
                paused = 1'b1;
                req_if.valid <= 1'b0;
                do @(negedge i_clk); while (frag_expect_q.size() != 0);
            end
            if (live_count >= QUIET_FROM) quiet = 1'b1;
            gaps_on = !quiet && $urandom_range(0, 2) != 0;
            kind    = $urandom_range(0, 9);
            if (kind <= 7) begin
                span = (kind == 7) ? 60 : 12;
                sx   = int'(t_coord'($urandom));
                sy   = int'(t_coord'($urandom));
                dx   = $urandom_range(0, 2 * span) - span;
                case ($urandom_range(0, 5))
                    0:       dy = dx;
                    1:       dy = -dx;
                    2:       dy = 0;
                    default: dy = $urandom_range(0, 2 * span) - span;
                endcase
                ex = clamp_end(sx, dx);
                ey = clamp_end(sy, dy);
                send_request('{OP_LOAD, t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey)});
                dx     = ex - sx;
                dy     = ey - sy;
                len    = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                                   : (dy < 0 ? -dy : dy);
                nsteps = (kind == 6) ? $urandom_range(0, len) : len + 1 + $urandom_range(0, 2);
                repeat (nsteps) send_request(step_req());
            end else if (kind == 8) begin
                r    = step_req();
                r.op = OP_LOAD;
                send_request(r);
                repeat ($urandom_range(0, 30)) send_request(step_req());
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    r    = step_req();
                    r.op = $urandom_range(0, 1) ? OP_STEP : OP_LOAD;
                    send_request(r);
                end
            end
        end

        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (frag_expect_q.size() != 0);
        repeat (8) @(negedge i_clk);

        $display("%0d requests (%0d loads, %0d lines stepped past their end), %0d fragments checked",
                 req_count, load_count, lines_finished, frags_checked);
        $display("directed extremes, zero-length and tie-break cases, random short and long lines");
        if (mismatches == 0 && frag_expect_q.size() == 0) begin
            $display("** bresenham_line_stepper: PASSED **");
        end else begin
            $display("** bresenham_line_stepper: FAILED **");
        end
        $finish;
    end

endmodule

// ===== bresenham_line_stepper.f =====
rtl/bls_pkg.sv
rtl/bls_ifs.sv
rtl/bls_engine.sv
rtl/bresenham_line_stepper.sv
dv/testbench.sv
